// File: rtl/brl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brl_pkg
// shared types, constants and helpers of the line rasterizer
// ----------------------------------------------------------------------------
package brl_pkg;

    localparam int SCREEN_SIZE = 64;
    localparam int COORD_W     = 6;
    localparam int COLOR_W     = 8;
    localparam int ERR_W       = COORD_W + 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 4;
    localparam int REG_IDX_W   = 2;

    localparam logic [COORD_W-1:0] SCREEN_MAX = COORD_W'(SCREEN_SIZE - 1);

    localparam logic [REG_IDX_W-1:0] REG_STROKE_ENABLE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_STROKE_RED    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_STROKE_GREEN  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_STROKE_BLUE   = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
    } t_line;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [COLOR_W-1:0] pixel_red;
        logic [COLOR_W-1:0] pixel_green;
        logic [COLOR_W-1:0] pixel_blue;
        logic               last_pixel;
    } t_pixel;

    // line in major/minor form, major axis always counts up
    typedef struct packed {
        logic               steep;
        logic               minor_neg;
        logic [COORD_W-1:0] maj0;
        logic [COORD_W-1:0] min0;
        logic [COORD_W-1:0] d_maj;
        logic [COORD_W-1:0] d_min;
    } t_seg;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_color;

    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
        clamp_coord = (v > SCREEN_MAX) ? SCREEN_MAX : v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/brl_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brl_front
// takes line beats, clamps endpoints and turns them into walk segments
// ----------------------------------------------------------------------------
module brl_front (
    input  wire logic          i_valid,
    input  wire brl_pkg::t_line i_line,
    output logic               o_stall,
    input  wire logic          i_enable,
    input  wire logic          i_full,
    output logic               o_push,
    output brl_pkg::t_seg      o_seg
);
    import brl_pkg::*;

    logic [COORD_W-1:0] ax, ay, bx, by;
    logic [COORD_W-1:0] adx, ady;
    logic               steep;
    logic               swap;

    always_comb begin
        ax  = clamp_coord(i_line.start_x);
        ay  = clamp_coord(i_line.start_y);
        bx  = clamp_coord(i_line.end_x);
        by  = clamp_coord(i_line.end_y);
        adx = (bx > ax) ? (bx - ax) : (ax - bx);
        ady = (by > ay) ? (by - ay) : (ay - by);
        steep = (ady >= adx);
        swap  = steep ? (ay > by) : (ax > bx);

        o_seg.steep = steep;
        if (steep) begin
            o_seg.maj0      = swap ? by : ay;
            o_seg.min0      = swap ? bx : ax;
            o_seg.minor_neg = swap ? (ax < bx) : (bx < ax);
            o_seg.d_maj     = ady;
            o_seg.d_min     = adx;
        end else begin
            o_seg.maj0      = swap ? bx : ax;
            o_seg.min0      = swap ? by : ay;
            o_seg.minor_neg = swap ? (ay < by) : (by < ay);
            o_seg.d_maj     = adx;
            o_seg.d_min     = ady;
        end
    end

    assign o_stall = i_full;
    // stroke off drops the beat
    assign o_push  = i_valid && !i_full && i_enable;

endmodule
`default_nettype wire

// File: rtl/brl_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brl_queue
// short segment queue between front and walker
// ----------------------------------------------------------------------------
module brl_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire brl_pkg::t_seg i_seg,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output brl_pkg::t_seg      o_seg
);
    import brl_pkg::*;

    t_seg              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_cnt;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_seg   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_seg;
        end
    end

endmodule
`default_nettype wire

// File: rtl/brl_walker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brl_walker
// steps one segment a pixel per unstalled cycle with the bresenham error term
// ----------------------------------------------------------------------------
module brl_walker (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_empty,
    input  wire brl_pkg::t_seg   i_seg,
    output logic                 o_pop,
    input  wire brl_pkg::t_color i_color,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output brl_pkg::t_pixel      o_pixel
);
    import brl_pkg::*;

    logic               r_busy;
    logic               r_steep;
    logic               r_neg;
    logic [COORD_W-1:0] r_maj;
    logic [COORD_W-1:0] r_min;
    logic [COORD_W-1:0] r_cnt;
    logic [COORD_W-1:0] r_dmaj;
    logic [COORD_W-1:0] r_dmin;
    logic [ERR_W-1:0]   r_err;
    logic               r_ovalid;
    t_pixel             r_opix;

    logic               emit;
    logic               step_min;
    logic [ERR_W-1:0]   n_err;
    logic [ERR_W-1:0]   n_err_init;
    logic [COORD_W-1:0] n_min;

    assign o_pop = !r_busy && !i_empty;
    assign emit  = r_busy && (!r_ovalid || !i_stall);

    always_comb begin
        step_min   = !r_err[ERR_W-1] && (r_err != '0);
        n_err      = r_err + ERR_W'({r_dmin, 1'b0});
        n_min      = r_min;
        if (step_min) begin
            n_err = n_err - ERR_W'({r_dmaj, 1'b0});
            n_min = r_neg ? (r_min - COORD_W'(1)) : (r_min + COORD_W'(1));
        end
        n_err_init = ERR_W'({i_seg.d_min, 1'b0}) - ERR_W'(i_seg.d_maj);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (emit && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_steep <= i_seg.steep;
            r_neg   <= i_seg.minor_neg;
            r_maj   <= i_seg.maj0;
            r_min   <= i_seg.min0;
            r_cnt   <= i_seg.d_maj;
            r_dmaj  <= i_seg.d_maj;
            r_dmin  <= i_seg.d_min;
            r_err   <= n_err_init;
        end else if (emit) begin
            r_maj <= r_maj + COORD_W'(1);
            r_min <= n_min;
            r_cnt <= r_cnt - COORD_W'(1);
            r_err <= n_err;
        end
        if (emit) begin
            r_opix.pixel_x     <= r_steep ? r_min : r_maj;
            r_opix.pixel_y     <= r_steep ? r_maj : r_min;
            r_opix.pixel_red   <= i_color.red;
            r_opix.pixel_green <= i_color.green;
            r_opix.pixel_blue  <= i_color.blue;
            r_opix.last_pixel  <= (r_cnt == '0);
        end
    end

    assign o_valid = r_ovalid;
    assign o_pixel = r_opix;

endmodule
`default_nettype wire

// File: rtl/bresenham_line_rasterizer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_unit
// line segment rasterizer: one pixel beat per cycle along the major axis while
// a line is walked and the output is not stalled
// the single pixel stepper takes a new line only after the last pixel beat of
// the one before; a two-entry queue holds lines behind it
// lines taken while stroke is off give no pixel beats
// reset: synchronous active low, clears queue, walker, output and registers
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire brl_pkg::t_line                    i_line,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output brl_pkg::t_pixel                        o_pixel,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [brl_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [brl_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [brl_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready
);
    import brl_pkg::*;

    logic               r_enable;
    t_color             r_color;
    logic [REG_IDX_W-1:0] reg_idx;
    logic               wr_en;

    logic               push;
    logic               full;
    logic               empty;
    logic               pop;
    t_seg               seg_in;
    t_seg               seg_out;

    assign pready  = 1'b1;
    assign reg_idx = paddr[REG_IDX_W+1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_color  <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_STROKE_ENABLE: r_enable      <= pwdata[0];
                REG_STROKE_RED:    r_color.red   <= pwdata[COLOR_W-1:0];
                REG_STROKE_GREEN:  r_color.green <= pwdata[COLOR_W-1:0];
                REG_STROKE_BLUE:   r_color.blue  <= pwdata[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_STROKE_ENABLE: prdata = APB_DATA_W'(r_enable);
            REG_STROKE_RED:    prdata = APB_DATA_W'(r_color.red);
            REG_STROKE_GREEN:  prdata = APB_DATA_W'(r_color.green);
            REG_STROKE_BLUE:   prdata = APB_DATA_W'(r_color.blue);
            default:           prdata = '0;
        endcase
    end

    brl_front u_front (
        .i_valid  (i_valid),
        .i_line   (i_line),
        .o_stall  (o_stall),
        .i_enable (r_enable),
        .i_full   (full),
        .o_push   (push),
        .o_seg    (seg_in)
    );

    brl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_seg   (seg_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_seg   (seg_out)
    );

    brl_walker u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_seg   (seg_out),
        .o_pop   (pop),
        .i_color (r_color),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_pixel (o_pixel)
    );

endmodule
`default_nettype wire
